@@ hdl/sorted_record_table_search_top_defines.svh @@
// Assertion macros used by the sorted record table sequencer (srts_ctrl).
`ifndef SORTED_RECORD_TABLE_SEARCH_TOP_DEFINES_SVH
`define SORTED_RECORD_TABLE_SEARCH_TOP_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define SRTS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off during rst
`define SRTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/srts_pkg.sv @@
// Types and constants of the sorted record table.
package srts_pkg;

  localparam int KEY_W   = 32;
  localparam int UNITS_W = 20;
  localparam int BILL_W  = 28;
  localparam int RATE_W  = 8;
  localparam int SLOT_W  = 8;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  localparam logic [RATE_W-1:0] RATE_RESET = 8'd2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [UNITS_W-1:0] units;
    logic [BILL_W-1:0]  bill;
  } rec_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [UNITS_W-1:0] units;
    logic [BILL_W-1:0]  bill;
  } res_t;

endpackage

@@ hdl/srts_mem.sv @@
// Record memory: one write port, one read port, registered read data.
module srts_mem #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output srts_pkg::rec_t                 rd_data,
  input  logic                           we,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  srts_pkg::rec_t                 wr_data
);
  import srts_pkg::*;

  rec_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/srts_ctrl.sv @@
// Sequencer: sorted insert with shift, midpoint search, update in place.
`include "sorted_record_table_search_top_defines.svh"

module srts_ctrl #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  logic [srts_pkg::KIND_W-1:0]      s_kind,
  input  logic [srts_pkg::KEY_W-1:0]       s_key,
  input  logic [srts_pkg::UNITS_W-1:0]     s_units,
  input  logic [srts_pkg::RATE_W-1:0]      rate,
  output logic                             res_valid,
  input  logic                             res_ready,
  output srts_pkg::res_t                   res,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  srts_pkg::rec_t                   rd_data,
  output logic                             we,
  output logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
  output srts_pkg::rec_t                   wr_data
);
  import srts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PLACE, S_PROBE, S_CMP, S_DONE
  } state_t;

  state_t             state;
  logic [KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [UNITS_W-1:0] units_q;
  logic [BILL_W-1:0]  bill_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi1;
  logic [CW-1:0]      mid_q;

  logic [CW-1:0]      idx_m1;
  logic [CW-1:0]      idx_m2;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic               shift_up;
  rec_t               new_rec;

  assign idx_m1   = idx - CW'(1);
  assign idx_m2   = idx - CW'(2);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi1} - (CW+1)'(1);
  assign mid      = mid_sum[CW:1];
  assign shift_up = rd_data.key > key_q;
  assign new_rec  = '{key: key_q, units: units_q, bill: bill_q};

  assign s_ready   = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    rd_addr = idx_m1[AW-1:0];
    we      = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = new_rec;
    unique case (state)
      S_INS_RD: begin
        we = (idx == '0);
      end
      S_INS_CMP: begin
        rd_addr = idx_m2[AW-1:0];
        we      = 1'b1;
        if (shift_up) begin
          wr_data = rd_data;
        end
      end
      S_INS_PLACE: begin
        we = 1'b1;
      end
      S_PROBE: begin
        rd_addr = mid[AW-1:0];
      end
      S_CMP: begin
        wr_addr = mid_q[AW-1:0];
        we      = (rd_data.key == key_q) && (kind_q == KIND_UPDATE);
        wr_data = '{key: rd_data.key, units: units_q, bill: bill_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_valid) begin
            kind_q  <= s_kind;
            key_q   <= s_key;
            units_q <= s_units;
            bill_q  <= BILL_W'(s_units) * BILL_W'(rate);
            idx     <= count;
            lo      <= '0;
            hi1     <= count;
            if (s_kind != KIND_INSERT) begin
              state <= S_PROBE;
            end else if (count == DEPTH_C) begin
              res   <= '{status: ST_FULL, slot: '0, units: '0, bill: '0};
              state <= S_DONE;
            end else begin
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            count <= count + CW'(1);
            res   <= '{status: ST_OK, slot: '0, units: units_q, bill: bill_q};
            state <= S_DONE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (shift_up) begin
            idx <= idx_m1;
            if (idx_m1 == '0) begin
              state <= S_INS_PLACE;
            end
          end else begin
            count <= count + CW'(1);
            res   <= '{status: ST_OK, slot: SLOT_W'(idx), units: units_q, bill: bill_q};
            state <= S_DONE;
          end
        end
        S_INS_PLACE: begin
          count <= count + CW'(1);
          res   <= '{status: ST_OK, slot: SLOT_W'(idx), units: units_q, bill: bill_q};
          state <= S_DONE;
        end
        S_PROBE: begin
          mid_q <= mid;
          if (lo < hi1) begin
            state <= S_CMP;
          end else begin
            res   <= '{status: ST_MISS, slot: '0, units: '0, bill: '0};
            state <= S_DONE;
          end
        end
        S_CMP: begin
          if (rd_data.key == key_q) begin
            if (kind_q == KIND_UPDATE) begin
              res <= '{status: ST_OK, slot: SLOT_W'(mid_q), units: units_q, bill: bill_q};
            end else begin
              res <= '{status: ST_OK, slot: SLOT_W'(mid_q), units: rd_data.units,
                       bill: rd_data.bill};
            end
            state <= S_DONE;
          end else begin
            if (rd_data.key < key_q) begin
              lo <= mid_q + CW'(1);
            end else begin
              hi1 <= mid_q;
            end
            state <= S_PROBE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRTS_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_C, "entry count above depth")
  `SRTS_ASSERT_NOW(a_full_only_when_full, res_valid && (res.status == ST_FULL),
                   count == DEPTH_C, "full reported with free slots")
  `SRTS_ASSERT_NOW(a_write_in_range, we, idx <= count, "write beyond filled region")
  `SRTS_ASSERT_NOW(a_probe_in_window, (state == S_PROBE) && (lo < hi1),
                   (mid >= lo) && (mid < hi1), "probe outside search window")
  `SRTS_ASSERT_NEXT(a_count_step, state != S_IDLE,
                    (count == $past(count)) || (count == $past(count) + CW'(1)),
                    "entry count jumped")

endmodule

@@ hdl/sorted_record_table_search_top.sv @@
// Top level of the sorted record table with binary search.
//
//  channel  direction  word contents (lsb first)
//  s_*      in         tdata: cust_key, units_in; tuser: kind
//  m_*      out        tdata: slot_index, units_out, bill_out; tuser: status
//  cfg_*    in         cfg_data: rate_per_unit
//
// Insert: shifts each stored key above the new key up one slot, one memory read and one
// shift write per cycle; a full table reports ST_FULL without a search. Lookup/update:
// binary search with one memory read per probe, ending on a hit or a miss. The next item
// can be taken in the same cycle that m_tvalid rises; s_tready is high only while idle.
// A finished word waits in the output register; the sequencer stalls while it is held.
// Reset empties the table and sets the rate to 2.
module sorted_record_table_search_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cust_key[31:0], units_in[51:32], zero pad
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // slot_index[7:0], units_out[27:8], bill_out[55:28]
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // rate_per_unit
);
  import srts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [RATE_W-1:0] rate;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_q;
  logic [AW-1:0]     rd_addr;
  rec_t              rd_data;
  logic              we;
  logic [AW-1:0]     wr_addr;
  rec_t              wr_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate     <= RATE_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        rate <= cfg_data;
      end
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        out_q    <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = out_q.status;
  assign m_tdata = {out_q.bill, out_q.units, out_q.slot};

  srts_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_kind    (s_tuser),
    .s_key     (s_tdata[31:0]),
    .s_units   (s_tdata[51:32]),
    .rate      (rate),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  srts_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
